/* hdl/sspc_pkg.sv */
package sspc_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned TOTAL_BITS = 9;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned IN_TDATA_BITS  = 8;
  localparam int unsigned OUT_TDATA_BITS = 48;
  localparam int unsigned APB_ADDR_BITS  = 3;
  localparam int unsigned APB_DATA_BITS  = 32;

  localparam logic [BYTE_BITS-1:0] HDR_BYTE = 8'hFF;
  localparam int unsigned MIN_PACKET  = 6;
  localparam int unsigned LEN_OFFSET  = 4;
  localparam int unsigned SUM_START   = 2;
  localparam int unsigned IDX_HDR0    = 0;
  localparam int unsigned IDX_HDR1    = 1;
  localparam int unsigned IDX_ID      = 2;
  localparam int unsigned IDX_LEN     = 3;
  localparam int unsigned IDX_ERR     = 4;
  localparam int unsigned IDX_PARAM_L = 5;
  localparam int unsigned IDX_PARAM_H = 6;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 9'h1FF;

  localparam logic [1:0] VW_WORD = 2'd2;

  typedef enum logic {
    REG_EXPECTED_ID = 1'b0,
    REG_VALUE_WIDTH = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_HEADER    = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_LENGTH    = 3'd4,
    ST_SERVO_ERR = 3'd5,
    ST_WRONG_ID  = 3'd6
  } status_e;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] byte_total;
    logic [VALUE_BITS-1:0] read_value;
    logic [BYTE_BITS-1:0]  error_bits;
    logic [BYTE_BITS-1:0]  servo_id;
    status_e               status;
  } result_t;

endpackage

/* hdl/servo_status_packet_checker.sv */
// Checks servo bus status replies arriving one byte per transaction on the
// slave stream (tlast on the final byte) and emits one verdict per reply on
// the master stream. A byte is taken every cycle while s_axis_tready is high,
// and the verdict is registered. A two-entry output buffer (result register
// plus skid register) keeps the input flowing while a verdict waits;
// s_axis_tready drops only when both entries are full.
// status codes: 0 ok, 1 short, 2 header, 3 checksum, 4 length, 5 servo error,
// 6 wrong id. read_value is zero unless status is ok. Registers: expected_id
// at 0x0, value_width at 0x4 (2 selects a little-endian word of bytes 5/6).
module servo_status_packet_checker #(
  parameter int unsigned COUNT_BITS = 9
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream, tdata: rx_byte[7:0]; tlast: last_byte
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [sspc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // master stream, tdata: status[2:0], servo_id[10:3], error_bits[18:11],
  // read_value[34:19], byte_total[43:35], zero[47:44]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [sspc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sspc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [sspc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [sspc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import sspc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [BYTE_BITS-1:0]  expected_id_q;
  logic [1:0]            value_width_q;

  logic [COUNT_BITS-1:0] byte_count_q;
  logic [BYTE_BITS-1:0]  running_sum_q;
  logic                  header_ok_q;
  logic [BYTE_BITS-1:0]  held_id_q, held_len_q, held_err_q, held_pl_q, held_ph_q;

  logic [COUNT_BITS-1:0] byte_count_d;
  logic [BYTE_BITS-1:0]  running_sum_d;
  logic                  header_ok_d;
  logic [BYTE_BITS-1:0]  held_id_d, held_len_d, held_err_d, held_pl_d, held_ph_d;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  logic                  s_acc, pop, push, cfg_wr;
  logic [BYTE_BITS-1:0]  rx;
  logic [COUNT_BITS-1:0] len_plus;
  status_e               status;

  assign rx     = s_axis_tdata[BYTE_BITS-1:0];
  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign pop    = out_valid_q && m_axis_tready;
  assign push   = s_acc && s_axis_tlast;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS - $bits(result_t)){1'b0}}, out_q};
  assign pready        = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= 8'd1;
      value_width_q <= 2'd1;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_EXPECTED_ID: expected_id_q <= pwdata[BYTE_BITS-1:0];
        REG_VALUE_WIDTH: value_width_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_EXPECTED_ID: prdata = {{(APB_DATA_BITS-BYTE_BITS){1'b0}}, expected_id_q};
      REG_VALUE_WIDTH: prdata = {{(APB_DATA_BITS-2){1'b0}}, value_width_q};
      default:         prdata = '0;
    endcase
  end

  // per-byte state update and verdict
  always_comb begin
    byte_count_d = (byte_count_q != COUNT_MAX) ? byte_count_q + 1'b1 : byte_count_q;
    header_ok_d  = header_ok_q;
    if ((byte_count_q == COUNT_BITS'(IDX_HDR0) || byte_count_q == COUNT_BITS'(IDX_HDR1))
        && rx != HDR_BYTE) begin
      header_ok_d = 1'b0;
    end
    held_id_d  = (byte_count_q == COUNT_BITS'(IDX_ID))      ? rx : held_id_q;
    held_len_d = (byte_count_q == COUNT_BITS'(IDX_LEN))     ? rx : held_len_q;
    held_err_d = (byte_count_q == COUNT_BITS'(IDX_ERR))     ? rx : held_err_q;
    held_pl_d  = (byte_count_q == COUNT_BITS'(IDX_PARAM_L)) ? rx : held_pl_q;
    held_ph_d  = (byte_count_q == COUNT_BITS'(IDX_PARAM_H)) ? rx : held_ph_q;
    running_sum_d = running_sum_q;
    if (byte_count_q >= COUNT_BITS'(SUM_START) && byte_count_q != COUNT_MAX) begin
      running_sum_d = running_sum_q + rx;
    end

    len_plus = COUNT_BITS'(held_len_d) + COUNT_BITS'(LEN_OFFSET);
    if (byte_count_d < COUNT_BITS'(MIN_PACKET)) begin
      status = ST_SHORT;
    end else if (!header_ok_d) begin
      status = ST_HEADER;
    end else if (~running_sum_q != rx) begin
      status = ST_CHECKSUM;
    end else if (len_plus != byte_count_d) begin
      status = ST_LENGTH;
    end else if (held_err_d != '0) begin
      status = ST_SERVO_ERR;
    end else if (held_id_d != expected_id_q) begin
      status = ST_WRONG_ID;
    end else begin
      status = ST_OK;
    end

    res.status     = status;
    res.servo_id   = held_id_d;
    res.error_bits = held_err_d;
    if (status != ST_OK) begin
      res.read_value = '0;
    end else if (value_width_q == VW_WORD) begin
      res.read_value = {held_ph_d, held_pl_d};
    end else begin
      res.read_value = {{(VALUE_BITS-BYTE_BITS){1'b0}}, held_pl_d};
    end
    if (byte_count_d > COUNT_BITS'(TOTAL_MAX)) begin
      res.byte_total = TOTAL_MAX;
    end else begin
      res.byte_total = byte_count_d[TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      running_sum_q <= '0;
      header_ok_q   <= 1'b1;
      held_id_q     <= '0;
      held_len_q    <= '0;
      held_err_q    <= '0;
      held_pl_q     <= '0;
      held_ph_q     <= '0;
    end else if (s_acc) begin
      if (s_axis_tlast) begin
        byte_count_q  <= '0;
        running_sum_q <= '0;
        header_ok_q   <= 1'b1;
        held_id_q     <= '0;
        held_len_q    <= '0;
        held_err_q    <= '0;
        held_pl_q     <= '0;
        held_ph_q     <= '0;
      end else begin
        byte_count_q  <= byte_count_d;
        running_sum_q <= running_sum_d;
        header_ok_q   <= header_ok_d;
        held_id_q     <= held_id_d;
        held_len_q    <= held_len_d;
        held_err_q    <= held_err_d;
        held_pl_q     <= held_pl_d;
        held_ph_q     <= held_ph_d;
      end
    end
  end

  // result register and skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register empty");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (byte_count_q == '0 && running_sum_q == '0 && header_ok_q))
    else $error("packet state not cleared after final byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tlast && byte_count_q != COUNT_MAX)
      |=> byte_count_q == $past(byte_count_q) + 1'b1)
    else $error("byte count did not advance");

  a_ok_long_enough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_OK)
      |-> out_q.byte_total >= TOTAL_BITS'(MIN_PACKET))
    else $error("ok verdict on a short reply");

  a_fail_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> out_q.read_value == '0)
    else $error("read value nonzero on failed verdict");
`endif

endmodule

/* verif/servo_status_packet_checker_tb.sv */
`timescale 1ns / 100ps

module servo_status_packet_checker_tb;
  import sspc_pkg::*;

  localparam int unsigned COUNT_BITS  = 9;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES = 100;

  typedef enum int {
    DAMAGE_NONE,
    DAMAGE_HEADER,
    DAMAGE_CHECKSUM,
    DAMAGE_LENGTH
  } damage_e;

  class reply_scoreboard;
    logic [7:0]  expected_id;
    logic [1:0]  value_width;
    int unsigned byte_count;
    logic [7:0]  running_sum;
    bit          header_ok;
    logic [7:0]  held_id;
    logic [7:0]  held_length;
    logic [7:0]  held_error;
    logic [7:0]  held_param_low;
    logic [7:0]  held_param_high;
    result_t     verdict_q[$];
    int unsigned mismatches;

    function new();
      expected_id = 8'd1;
      value_width = 2'd1;
      mismatches  = 0;
      clear();
    endfunction

    function void clear();
      byte_count      = 0;
      running_sum     = 8'h00;
      header_ok       = 1'b1;
      held_id         = 8'h00;
      held_length     = 8'h00;
      held_error      = 8'h00;
      held_param_low  = 8'h00;
      held_param_high = 8'h00;
    endfunction

    function void set_reg(reg_idx_e r, logic [31:0] value);
      if (r == REG_EXPECTED_ID) begin
        expected_id = value[7:0];
      end else begin
        value_width = value[1:0];
      end
    endfunction

    function void take_byte(logic [7:0] b, bit last);
      int unsigned idx;
      int unsigned n;
      result_t v;
      idx = byte_count;
      if (byte_count < COUNT_MAX) byte_count++;
      if ((idx == IDX_HDR0 || idx == IDX_HDR1) && b != HDR_BYTE) header_ok = 1'b0;
      if (idx == IDX_ID) held_id = b;
      if (idx == IDX_LEN) held_length = b;
      if (idx == IDX_ERR) held_error = b;
      if (idx == IDX_PARAM_L) held_param_low = b;
      if (idx == IDX_PARAM_H) held_param_high = b;
      if (!last) begin
        if (idx >= SUM_START && idx < COUNT_MAX) running_sum = running_sum + b;
        return;
      end
      n = byte_count;
      if (n < MIN_PACKET) begin
        v.status = ST_SHORT;
      end else if (!header_ok) begin
        v.status = ST_HEADER;
      end else if (8'(~running_sum) != b) begin
        v.status = ST_CHECKSUM;
      end else if (int'(held_length) + LEN_OFFSET != n) begin
        v.status = ST_LENGTH;
      end else if (held_error != 8'h00) begin
        v.status = ST_SERVO_ERR;
      end else if (held_id != expected_id) begin
        v.status = ST_WRONG_ID;
      end else begin
        v.status = ST_OK;
      end
      if (v.status != ST_OK) begin
        v.read_value = '0;
      end else if (value_width == VW_WORD) begin
        v.read_value = {held_param_high, held_param_low};
      end else begin
        v.read_value = {8'h00, held_param_low};
      end
      v.servo_id   = held_id;
      v.error_bits = held_error;
      v.byte_total = (n > TOTAL_MAX) ? TOTAL_MAX : TOTAL_BITS'(n);
      verdict_q.push_back(v);
      clear();
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(logic [OUT_TDATA_BITS-1:0] tdata);
      result_t want;
      result_t got;
      if (verdict_q.size() == 0) begin
        $error("verdict with none pending, tdata %h", tdata);
        mismatches++;
        return;
      end
      want = verdict_q.pop_front();
      got  = result_t'(tdata[$bits(result_t)-1:0]);
      compare("status", want.status, got.status);
      compare("servo_id", want.servo_id, got.servo_id);
      compare("error_bits", want.error_bits, got.error_bits);
      compare("read_value", want.read_value, got.read_value);
      compare("byte_total", want.byte_total, got.byte_total);
      compare("padding", 0, tdata[OUT_TDATA_BITS-1:$bits(result_t)]);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  reply_scoreboard sb = new();
  bit          idle_on = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  reply_bytes[$];

  servo_status_packet_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (idle_on) begin
      m_axis_tready <= ($urandom_range(99) >= 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_e r, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    while (idle_on && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_reply();
    foreach (reply_bytes[i]) send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
  endtask

  // header, id, length, error, params, checksum over bytes 2 and up
  task automatic form_reply(input logic [7:0] id, input int unsigned nparams,
                            input logic [7:0] err, input damage_e damage);
    logic [7:0] len;
    logic [7:0] sum;
    len = 8'(nparams + 2);
    if (damage == DAMAGE_LENGTH) len = len ^ 8'($urandom_range(1, 255));
    reply_bytes = {HDR_BYTE, HDR_BYTE, id, len, err};
    repeat (nparams) reply_bytes.push_back(8'($urandom_range(255)));
    sum = 8'h00;
    for (int i = SUM_START; i < reply_bytes.size(); i++) sum = sum + reply_bytes[i];
    if (damage == DAMAGE_CHECKSUM) sum = sum ^ 8'($urandom_range(1, 255));
    reply_bytes.push_back(~sum);
    if (damage == DAMAGE_HEADER) reply_bytes[$urandom_range(1)] = 8'($urandom_range(254));
  endtask

  task automatic fill_noise(input int unsigned n, input bit with_header);
    reply_bytes.delete();
    if (with_header) reply_bytes = {HDR_BYTE, HDR_BYTE};
    while (reply_bytes.size() < n) reply_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_reply();
    int unsigned pick;
    int unsigned sub;
    int unsigned nparams;
    logic [7:0]  id;
    pick    = $urandom_range(99);
    sub     = $urandom_range(9);
    nparams = ($urandom_range(9) == 0) ? $urandom_range(253) : $urandom_range(4);
    id      = sb.expected_id;
    if (pick < 70) begin
      case (sub)
        5: form_reply(id, nparams, 8'h00, DAMAGE_HEADER);
        6: form_reply(id, nparams, 8'h00, DAMAGE_CHECKSUM);
        7: form_reply(id, nparams, 8'h00, DAMAGE_LENGTH);
        8: form_reply(id, nparams, 8'($urandom_range(1, 255)), DAMAGE_NONE);
        9: form_reply(id ^ 8'($urandom_range(1, 255)), nparams, 8'h00, DAMAGE_NONE);
        default: form_reply(id, nparams, 8'h00, DAMAGE_NONE);
      endcase
    end else if (pick < 80) begin
      fill_noise($urandom_range(1, 12), 1'b0);
    end else if (pick < 88) begin
      form_reply(id, nparams, 8'h00, DAMAGE_NONE);
      repeat ($urandom_range(reply_bytes.size() - 1)) void'(reply_bytes.pop_back());
    end else begin
      form_reply(8'($urandom_range(255)), nparams, 8'($urandom_range(255)), DAMAGE_NONE);
    end
    send_reply();
  endtask

  initial begin
    int unsigned phase_start;
    logic [7:0]  id_setting[6];
    logic [1:0]  width_setting[6];
    id_setting    = '{8'd0, 8'd255, 8'($urandom_range(255)), 8'd1,
                      8'($urandom_range(255)), 8'd255};
    width_setting = '{VW_WORD, 2'd1, 2'd0, 2'd3, VW_WORD, 2'd1};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset configuration: lone final byte, six-byte reply, bad header, one param, short
    reply_bytes = {8'h00};
    send_reply();
    form_reply(8'd1, 0, 8'h00, DAMAGE_NONE);
    send_reply();
    form_reply(8'd1, 0, 8'h00, DAMAGE_HEADER);
    send_reply();
    form_reply(8'd1, 1, 8'h00, DAMAGE_NONE);
    send_reply();
    form_reply(8'd1, 0, 8'h00, DAMAGE_NONE);
    void'(reply_bytes.pop_back());
    send_reply();
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      apb_write(REG_EXPECTED_ID, {24'h0, id_setting[p]});
      apb_write(REG_VALUE_WIDTH, {30'h0, width_setting[p]});
      idle_on = (p != 2);
      // counter saturation around the top of the byte counter
      if (p == 1) begin
        fill_noise(520, 1'b1);
        send_reply();
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) random_reply();
      wait_idle();
    end
    idle_on = 1'b1;

    if (sb.mismatches == 0 && sb.verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* servo_status_packet_checker.f */
hdl/sspc_pkg.sv
hdl/servo_status_packet_checker.sv
verif/servo_status_packet_checker_tb.sv
